/* hw/rtl/prime_power_decomposer_unit_macros.svh */
// Assertion macros shared by the prime power decomposer RTL.
`ifndef PRIME_POWER_DECOMPOSER_UNIT_MACROS_SVH
`define PRIME_POWER_DECOMPOSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define PPD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define PPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define PPD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PPD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/ppd_pkg.sv */
// Constants shared by the prime power decomposer.
package ppd_pkg;

	localparam int VALUE_WIDTH = 31;
	localparam int EXP_WIDTH   = 5;
	localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);

	localparam logic [EXP_WIDTH-1:0]   EXP_MAX  = '1;
	localparam logic [CNT_WIDTH-1:0]   CNT_LAST = CNT_WIDTH'(VALUE_WIDTH - 1);
	localparam logic [VALUE_WIDTH-1:0] FIRST_DIVISOR  = VALUE_WIDTH'(2);
	localparam logic [VALUE_WIDTH-1:0] SECOND_DIVISOR = VALUE_WIDTH'(3);
	localparam logic [VALUE_WIDTH-1:0] DIVISOR_STEP   = VALUE_WIDTH'(2);

endpackage

/* hw/rtl/prime_power_decomposer_unit.sv */
// Prime power decomposer: trial division with a one-bit-per-cycle restoring divider.
// Timing: a word of 0 or 1 answers in the cycle after it is accepted. Any other word runs
// one division per trial divisor (2, 3, then odd numbers upward) and one per further power
// of the factor, then strobes the result. The worst case, a prime near 2^31, takes about
// 23200 trial divisions.
// One word at a time: busy stays high until done pulses; the receiver cannot stall done.
// Reset (arst_n low, asynchronous) returns the block to idle with done and busy low.
`include "prime_power_decomposer_unit_macros.svh"

module prime_power_decomposer_unit import ppd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic                   done,
	output logic [VALUE_WIDTH-1:0] prime_base,
	output logic [EXP_WIDTH-1:0]   exponent,
	output logic                   is_prime_power
);

	// Controller states.
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;	// looking for the smallest factor
	localparam logic [1:0] ST_POWER  = 2'd2;	// dividing out the factor

	logic [1:0]             state_q;
	logic [CNT_WIDTH-1:0]   cnt_q;		// quotient bit being produced
	logic [VALUE_WIDTH-1:0] num_q;		// value currently being factored
	logic [VALUE_WIDTH-1:0] div_q;		// dividend shifting out, quotient shifting in
	logic [VALUE_WIDTH-1:0] rem_q;		// partial remainder, always below k_q
	logic [VALUE_WIDTH-1:0] k_q;		// current divisor
	logic [EXP_WIDTH-1:0]   exp_q;		// exact divisions by the factor so far, saturating

	logic                   done_q;
	logic [VALUE_WIDTH-1:0] base_q;
	logic [EXP_WIDTH-1:0]   expo_q;
	logic                   flag_q;

	// One restoring-division step: bring down the next dividend bit and try to subtract.
	logic [VALUE_WIDTH:0]   rem_sh;
	logic                   qbit;
	logic [VALUE_WIDTH-1:0] rem_nx;
	logic [VALUE_WIDTH-1:0] quo_nx;
	logic                   last;
	logic [EXP_WIDTH-1:0]   exp_inc;

	always_comb begin
		rem_sh  = {rem_q, div_q[VALUE_WIDTH-1]};
		qbit    = rem_sh >= {1'b0, k_q};
		rem_nx  = qbit ? VALUE_WIDTH'(rem_sh - {1'b0, k_q}) : rem_sh[VALUE_WIDTH-1:0];
		quo_nx  = {div_q[VALUE_WIDTH-2:0], qbit};
		last    = cnt_q == CNT_LAST;
		exp_inc = (exp_q == EXP_MAX) ? exp_q : exp_q + EXP_WIDTH'(1);
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (start) begin
						if (value > VALUE_WIDTH'(1)) begin
							state_q <= ST_SEARCH;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				ST_SEARCH: begin
					cnt_q <= last ? '0 : cnt_q + CNT_WIDTH'(1);
					if (last) begin
						if (quo_nx < k_q) begin
							// No factor up to the square root: the value is prime.
							state_q <= ST_IDLE;
							done_q  <= 1'b1;
						end else if (rem_nx == '0) begin
							state_q <= ST_POWER;
						end
					end
				end
				ST_POWER: begin
					cnt_q <= last ? '0 : cnt_q + CNT_WIDTH'(1);
					if (last && (rem_nx != '0 || quo_nx == VALUE_WIDTH'(1))) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath and result registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					num_q  <= value;
					div_q  <= value;
					rem_q  <= '0;
					k_q    <= FIRST_DIVISOR;
					exp_q  <= '0;
					base_q <= '0;
					expo_q <= '0;
					flag_q <= 1'b0;
				end
			end
			ST_SEARCH: begin
				if (last) begin
					rem_q <= '0;
					if (quo_nx < k_q) begin
						base_q <= num_q;
						expo_q <= EXP_WIDTH'(1);
						flag_q <= 1'b1;
					end else if (rem_nx == '0) begin
						// First power found; divide the quotient next.
						num_q <= quo_nx;
						div_q <= quo_nx;
						exp_q <= EXP_WIDTH'(1);
					end else begin
						div_q <= num_q;
						k_q   <= (k_q == FIRST_DIVISOR) ? SECOND_DIVISOR : k_q + DIVISOR_STEP;
					end
				end else begin
					rem_q <= rem_nx;
					div_q <= quo_nx;
				end
			end
			ST_POWER: begin
				if (last) begin
					rem_q <= '0;
					if (rem_nx != '0) begin
						base_q <= '0;
						expo_q <= exp_q;
						flag_q <= 1'b0;
					end else if (quo_nx == VALUE_WIDTH'(1)) begin
						base_q <= k_q;
						expo_q <= exp_inc;
						flag_q <= 1'b1;
					end else begin
						num_q <= quo_nx;
						div_q <= quo_nx;
						exp_q <= exp_inc;
					end
				end else begin
					rem_q <= rem_nx;
					div_q <= quo_nx;
				end
			end
			default: begin
				rem_q <= '0;
			end
		endcase
	end

	assign busy           = state_q != ST_IDLE;
	assign done           = done_q;
	assign prime_base     = base_q;
	assign exponent       = expo_q;
	assign is_prime_power = flag_q;

	// A result only appears once the divider has returned to idle.
	`PPD_ASSERT_SAME(a_done_idle, clk, arst_n, done_q, !busy)
	// A prime power always carries a real base and a nonzero exponent.
	`PPD_ASSERT_SAME(a_power_fields, clk, arst_n, done_q && flag_q,
		base_q >= VALUE_WIDTH'(2) && expo_q != '0)
	// A failed decomposition reports a zero base.
	`PPD_ASSERT_SAME(a_fail_base, clk, arst_n, done_q && !flag_q, base_q == '0)
	// The partial remainder stays below the divisor throughout a division.
	`PPD_ASSERT_SAME(a_rem_bound, clk, arst_n, busy, rem_q < k_q && k_q >= FIRST_DIVISOR)
	// A word above one starts the divider in the next cycle.
	`PPD_ASSERT_NEXT(a_start_busy, clk, arst_n,
		start && !busy && value > VALUE_WIDTH'(1), busy && !done_q)

endmodule

/* dv/tb_prime_power_decomposer_unit.sv */
// Self-checking testbench for the prime power decomposer: directed and random words.
module tb_prime_power_decomposer_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import ppd_pkg::*;

	// The largest word that fits the input port; all arithmetic below runs in 64 bits.
	localparam longint unsigned WORD_MAX = (64'd1 << VALUE_WIDTH) - 64'd1;
	// Cycles to keep watching after the last expected result, to catch a stray done.
	localparam int DRAIN_CYCLES = 64;
	// Watchdog limit for the whole run, in nanoseconds.
	localparam longint TIMEOUT_NS = 64'd60_000_000;

	// One expected answer, tagged with the word that caused it.
	typedef struct packed {
		logic [VALUE_WIDTH-1:0] word;
		logic [VALUE_WIDTH-1:0] base;
		logic [EXP_WIDTH-1:0]   power;
		logic                   flag;
	} decomp_t;

	// Shapes of random words. Most have small factors so that trial division stays short.
	typedef enum {KIND_SMALL, KIND_POWER, KIND_MIXED, KIND_WIDE} word_kind_t;

	// The scoreboard holds the predictor and the answers still owed by the block.
	class decomp_scoreboard;
		decomp_t pending[$];
		int unsigned errors;

		// Smallest divisor k >= 2 with k*k <= v, or 0 when v has none (v prime or tiny).
		static function longint unsigned smallest_divisor(longint unsigned v);
			longint unsigned k;
			if (v % 2 == 0)
				return (v >= 4) ? 64'd2 : 64'd0;
			for (k = 3; k <= v / k; k += 2) begin
				if (v % k == 0)
					return k;
			end
			return 64'd0;
		endfunction

		function decomp_t decompose(logic [VALUE_WIDTH-1:0] word);
			decomp_t d;
			longint unsigned v;
			longint unsigned f;
			longint unsigned count;
			v = longint'(word);
			count = 0;
			d.word = word;
			d.base = '0;
			d.flag = 1'b0;
			if (v > 1) begin
				f = smallest_divisor(v);
				if (f == 0) begin
					// No factor up to the square root: the word is itself prime.
					d.base = word;
					d.flag = 1'b1;
					count = 1;
				end else begin
					// Strip the smallest factor until either nothing is left or a
					// remainder shows that another prime is present.
					forever begin
						if (v == 1) begin
							d.base = VALUE_WIDTH'(f);
							d.flag = 1'b1;
							break;
						end
						if (v % f != 0)
							break;
						v = v / f;
						count++;
					end
				end
			end
			if (count > longint'(EXP_MAX))
				count = longint'(EXP_MAX);
			d.power = EXP_WIDTH'(count);
			return d;
		endfunction

		function void note_word(logic [VALUE_WIDTH-1:0] word);
			pending.push_back(decompose(word));
		endfunction

		task flag_mismatch(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic [VALUE_WIDTH-1:0] base, logic [EXP_WIDTH-1:0] power,
				logic flag);
			decomp_t want;
			if (pending.size() == 0) begin
				flag_mismatch($sformatf("unexpected result base %0d exponent %0d flag %b",
					base, power, flag));
				return;
			end
			want = pending.pop_front();
			if (base !== want.base)
				flag_mismatch($sformatf("word %0d: prime_base %0d, want %0d",
					want.word, base, want.base));
			if (power !== want.power)
				flag_mismatch($sformatf("word %0d: exponent %0d, want %0d",
					want.word, power, want.power));
			if (flag !== want.flag)
				flag_mismatch($sformatf("word %0d: is_prime_power %b, want %b",
					want.word, flag, want.flag));
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [VALUE_WIDTH-1:0] value;
	logic                   done;
	logic [VALUE_WIDTH-1:0] prime_base;
	logic [EXP_WIDTH-1:0]   exponent;
	logic                   is_prime_power;

	decomp_scoreboard sb = new();

	// Directed words: zero and one, the smallest primes and composites, squares of primes,
	// the largest powers of 2, 3, 5 and 7 that fit, non-powers with all high bits set, and
	// the largest word, which is prime and is the slowest case the block can meet.
	logic [VALUE_WIDTH-1:0] directed_words[$] = '{
		31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd6, 31'd8, 31'd9, 31'd12,
		31'd25, 31'd169, 31'd63001, 31'd65521, 31'd1073741824, 31'd1162261467,
		31'd1220703125, 31'd1977326743, 31'd2147483645, 31'd2147483646, 31'd2147483647
	};

	prime_power_decomposer_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.value          (value),
		.done           (done),
		.prime_base     (prime_base),
		.exponent       (exponent),
		.is_prime_power (is_prime_power)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The block cannot be held off, so every cycle with done high carries a result word.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(prime_base, exponent, is_prime_power);
	end

	// Smallest prime that is not below x.
	function automatic longint unsigned next_prime(longint unsigned x);
		while (x < 2 || decomp_scoreboard::smallest_divisor(x) != 0)
			x++;
		return x;
	endfunction

	function automatic logic [VALUE_WIDTH-1:0] random_word(word_kind_t kind);
		longint unsigned p;
		longint unsigned q;
		longint unsigned pw;
		longint unsigned lim;
		int nmax;
		int n;
		case (kind)
			KIND_SMALL: begin
				// Small words: primes here cost at most about 130 trial divisions.
				return VALUE_WIDTH'($urandom_range(0, 65535));
			end
			KIND_WIDE: begin
				// Full-width words forced onto a multiple of a small prime, so that every
				// input bit toggles without paying for a long trial-division search.
				q = next_prime($urandom_range(2, 13));
				return VALUE_WIDTH'((longint'($urandom) & WORD_MAX) / q * q);
			end
			default: begin
				// A power of a small prime; for mixed words one other prime factor is
				// folded in, which ends the division chain early with a partial count.
				p = next_prime($urandom_range(2, 255));
				q = 1;
				if (kind == KIND_MIXED) begin
					q = next_prime($urandom_range(2, 31));
					if (q == p)
						q = next_prime(q + 1);
				end
				lim = WORD_MAX / q;
				nmax = 1;
				pw = p;
				while (pw * p <= lim) begin
					pw = pw * p;
					nmax++;
				end
				n = $urandom_range(1, nmax);
				pw = q;
				repeat (n) pw = pw * p;
				return VALUE_WIDTH'(pw);
			end
		endcase
	endfunction

	// Presents one word and returns in the time step at which it was accepted. The sender
	// drops start at random in idle_pct of the cycles, also while the block is busy, so
	// idle cycles land on every phase of the search. start is assigned once per step.
	task automatic send_word(logic [VALUE_WIDTH-1:0] word, int idle_pct);
		logic taken;
		taken = 1'b0;
		value <= word;
		while (!taken) begin
			start <= ($urandom_range(0, 99) >= idle_pct);
			@(posedge clk);
			taken = start && !busy;
		end
		sb.note_word(word);
	endtask

	task automatic send_random(int count, int idle_pct);
		word_kind_t kind;
		int pick;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				kind = KIND_SMALL;
			else if (pick < 65)
				kind = KIND_POWER;
			else if (pick < 80)
				kind = KIND_MIXED;
			else
				kind = KIND_WIDE;
			send_word(random_word(kind), idle_pct);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words go back to back, with start held high between them.
		foreach (directed_words[i])
			send_word(directed_words[i], 0);

		// Random words: light sender idling, then heavy idling, then none at all.
		send_random(34, 8);
		send_random(33, 86);
		send_random(33, 0);
		start <= 1'b0;

		// Wait for every owed result, then watch a little longer for stray strobes.
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#TIMEOUT_NS;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/ppd_pkg.sv
hw/rtl/prime_power_decomposer_unit.sv
dv/tb_prime_power_decomposer_unit.sv
